/* rtl/grt_pkg.sv */
// Shared types and constants for the grid ray traversal block.
package grt_pkg;

   localparam int COORD_W = 24;
   localparam int DIR_W   = 18;
   localparam int CELL_W  = 12;
   localparam int T_W     = 34;
   localparam int DIVN_W  = 33;

   typedef enum logic [1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1,
      CSR_MAX_RANGE  = 2'd2
   } grt_csr_type;

   typedef enum logic [1:0] {
      DIV_X_START = 2'd0,
      DIV_X_STEP  = 2'd1,
      DIV_Y_START = 2'd2,
      DIV_Y_STEP  = 2'd3
   } grt_div_sel_type;

   localparam logic KIND_MAP_WRITE = 1'b0;
   localparam logic KIND_RAY_CAST  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic [7:0]  cell_value;
      logic [23:0] start_x;
      logic [23:0] start_y;
      logic [17:0] dir_x;
      logic [17:0] dir_y;
   } grt_req_type;

   typedef struct packed {
      logic        hit;
      logic [23:0] end_x;
      logic [23:0] end_y;
      logic [23:0] distance;
      logic [7:0]  wall_type;
      logic        normal_is_y;
   } grt_rsp_type;

   typedef struct packed {
      logic            clr_step;
      logic            map_wr;
      logic            load;
      logic            div_start;
      grt_div_sel_type div_sel;
      logic            step;
      logic            look;
      logic            rsp_load;
      logic            rsp_miss;
   } grt_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic div_done;
      logic zero_dir;
      logic t_over;
      logic cell_hit;
      logic end_fits;
   } grt_status_type;

endpackage

/* rtl/grt_ctrl.sv */
// Sequencer for map clearing, divider passes and the cell walk.
module grt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  grt_pkg::grt_status_type st,
   output grt_pkg::grt_cmd_type    cmd
);
   import grt_pkg::*;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_SETUP = 8'b0000_0100,
      S_DIV   = 8'b0000_1000,
      S_STEP  = 8'b0001_0000,
      S_FETCH = 8'b0010_0000,
      S_CHECK = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type       state_ff, state_in;
   grt_div_sel_type sel_ff, sel_in;
   logic            miss_ff, miss_in;
   logic            rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.div_sel  = sel_ff;
      cmd.rsp_miss = miss_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_RAY_CAST) begin
                  cmd.load = 1'b1;
                  sel_in   = DIV_X_START;
                  miss_in  = 1'b0;
                  state_in = S_SETUP;
               end else begin
                  cmd.map_wr = 1'b1;
               end
            end
         end
         S_SETUP: begin
            if (st.zero_dir) begin
               miss_in  = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (st.div_done) begin
               if (sel_ff == DIV_Y_STEP) begin
                  state_in = S_STEP;
               end else begin
                  sel_in   = grt_div_sel_type'(sel_ff + 2'd1);
                  state_in = S_SETUP;
               end
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.look = 1'b1;
            if (st.t_over) begin
               miss_in  = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.cell_hit) begin
               miss_in  = !st.end_fits;
               state_in = S_RESP;
            end else begin
               state_in = S_STEP;
            end
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sel_ff       <= DIV_X_START;
         miss_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/grt_dpath.sv */
// Map store, serial divider, step accumulators and result register.
module grt_dpath #(
   parameter int MAX_MAP_WIDTH  = 64,
   parameter int MAX_MAP_HEIGHT = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  grt_pkg::grt_req_type    req_data,
   output grt_pkg::grt_rsp_type    rsp_data,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [23:0]             csr_wdata,
   input  grt_pkg::grt_cmd_type    cmd,
   output grt_pkg::grt_status_type st
);
   import grt_pkg::*;

   localparam int DEPTH = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration
   logic [6:0]  map_width_ff, map_height_ff;
   logic [23:0] max_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= 7'd64;
         map_height_ff <= 7'd64;
         max_range_ff  <= 24'h10_0000;
      end else if (csr_we) begin
         case (grt_csr_type'(csr_index))
            CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata[6:0];
            CSR_MAP_HEIGHT: map_height_ff <= csr_wdata[6:0];
            CSR_MAX_RANGE:  max_range_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ray registers
   logic signed [COORD_W-1:0] sx_ff, sy_ff;
   logic signed [DIR_W-1:0]   dx_ff, dy_ff;
   logic signed [CELL_W-1:0]  cx_ff, cy_ff;
   logic [T_W-1:0]            tx_ff, ty_ff, t_ff;
   logic [DIR_W-1:0]          rx_ff, ry_ff, rdx_ff, rdy_ff;
   logic [DIVN_W-1:0]         qdx_ff, qdy_ff;
   logic signed [CELL_W:0]    nb_ff;
   logic                      axis_ff;
   logic signed [42:0]        prod_ff;
   logic [7:0]                rd_ff;
   logic                      in_map_ff;
   grt_rsp_type               rsp_ff;

   logic [DIR_W-1:0]       adx, ady;
   logic                   dx_pos, dy_pos;
   logic signed [CELL_W:0] nbx, nby;
   logic signed [28:0]     diff_x, diff_y;
   logic [16:0]            unx, uny;

   assign adx    = dx_ff[DIR_W-1] ? DIR_W'(-dx_ff) : dx_ff;
   assign ady    = dy_ff[DIR_W-1] ? DIR_W'(-dy_ff) : dy_ff;
   assign dx_pos = !dx_ff[DIR_W-1] && (dx_ff != '0);
   assign dy_pos = !dy_ff[DIR_W-1] && (dy_ff != '0);
   assign nbx    = (CELL_W+1)'(cx_ff) + (CELL_W+1)'(dx_pos);
   assign nby    = (CELL_W+1)'(cy_ff) + (CELL_W+1)'(dy_pos);
   assign diff_x = {nbx, 16'b0} - 29'(sx_ff);
   assign diff_y = {nby, 16'b0} - 29'(sy_ff);
   // first boundary lies within one cell, so the magnitude is at most one cell
   assign unx    = diff_x[28] ? 17'(-diff_x) : diff_x[16:0];
   assign uny    = diff_y[28] ? 17'(-diff_y) : diff_y[16:0];

   // restoring divider, one quotient bit per cycle
   logic [DIVN_W-1:0] div_num_ff;
   logic [DIR_W-1:0]  div_den_ff, div_rem_ff;
   logic [5:0]        div_cnt_ff;
   logic              div_busy_ff, div_fin_ff;
   grt_div_sel_type   div_sel_ff;
   logic [DIR_W:0]    div_trial;
   logic              div_qbit;

   assign div_trial = {div_rem_ff, div_num_ff[DIVN_W-1]};
   assign div_qbit  = (div_trial >= {1'b0, div_den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_fin_ff  <= 1'b0;
      end else begin
         div_fin_ff <= 1'b0;
         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
         end else if (div_busy_ff && div_cnt_ff == '0) begin
            div_busy_ff <= 1'b0;
            div_fin_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_sel_ff <= cmd.div_sel;
         div_cnt_ff <= 6'(DIVN_W - 1);
         div_rem_ff <= '0;
         case (cmd.div_sel)
            DIV_X_START: begin
               div_num_ff <= {unx, 16'b0};
               div_den_ff <= adx;
            end
            DIV_Y_START: begin
               div_num_ff <= {uny, 16'b0};
               div_den_ff <= ady;
            end
            DIV_X_STEP: begin
               div_num_ff <= DIVN_W'(33'h1_0000_0000);
               div_den_ff <= adx;
            end
            default: begin
               div_num_ff <= DIVN_W'(33'h1_0000_0000);
               div_den_ff <= ady;
            end
         endcase
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - 6'd1;
         div_num_ff <= {div_num_ff[DIVN_W-2:0], div_qbit};
         div_rem_ff <= div_qbit ? DIR_W'(div_trial - {1'b0, div_den_ff})
                                : div_trial[DIR_W-1:0];
      end
   end

   // step selection and incremental crossing times
   logic           take_x;
   logic [DIR_W:0] rx_sum, ry_sum;
   logic           cx_carry, cy_carry;

   assign take_x   = (dx_ff != '0) && ((dy_ff == '0) || (tx_ff <= ty_ff));
   assign rx_sum   = {1'b0, rx_ff} + {1'b0, rdx_ff};
   assign ry_sum   = {1'b0, ry_ff} + {1'b0, rdy_ff};
   assign cx_carry = (rx_sum >= {1'b0, adx});
   assign cy_carry = (ry_sum >= {1'b0, ady});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff <= req_data.start_x;
         sy_ff <= req_data.start_y;
         dx_ff <= req_data.dir_x;
         dy_ff <= req_data.dir_y;
         cx_ff <= CELL_W'($signed(req_data.start_x) >>> 16);
         cy_ff <= CELL_W'($signed(req_data.start_y) >>> 16);
      end else if (cmd.step) begin
         if (take_x) begin
            t_ff    <= tx_ff;
            nb_ff   <= nbx;
            axis_ff <= 1'b0;
            cx_ff   <= dx_pos ? cx_ff + CELL_W'(1) : cx_ff - CELL_W'(1);
            rx_ff   <= cx_carry ? DIR_W'(rx_sum - {1'b0, adx}) : rx_sum[DIR_W-1:0];
            tx_ff   <= tx_ff + T_W'(qdx_ff) + T_W'(cx_carry);
         end else begin
            t_ff    <= ty_ff;
            nb_ff   <= nby;
            axis_ff <= 1'b1;
            cy_ff   <= dy_pos ? cy_ff + CELL_W'(1) : cy_ff - CELL_W'(1);
            ry_ff   <= cy_carry ? DIR_W'(ry_sum - {1'b0, ady}) : ry_sum[DIR_W-1:0];
            ty_ff   <= ty_ff + T_W'(qdy_ff) + T_W'(cy_carry);
         end
      end else if (div_fin_ff) begin
         case (div_sel_ff)
            DIV_X_START: begin
               tx_ff <= T_W'(div_num_ff);
               rx_ff <= div_rem_ff;
            end
            DIV_Y_START: begin
               ty_ff <= T_W'(div_num_ff);
               ry_ff <= div_rem_ff;
            end
            DIV_X_STEP: begin
               qdx_ff <= div_num_ff;
               rdx_ff <= div_rem_ff;
            end
            default: begin
               qdy_ff <= div_num_ff;
               rdy_ff <= div_rem_ff;
            end
         endcase
      end
   end

   // map store with clearing sweep
   logic [7:0]    mem_ff [DEPTH];
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_ok;
   logic [8:0]    w_eff, h_eff;
   logic          in_map;

   assign wr_addr = AW'(32'(req_data.cell_y) * 32'(MAX_MAP_WIDTH) + 32'(req_data.cell_x));
   assign wr_ok   = (32'(req_data.cell_x) < 32'(MAX_MAP_WIDTH))
                 && (32'(req_data.cell_y) < 32'(MAX_MAP_HEIGHT));
   assign rd_addr = AW'(32'(cy_ff[CELL_W-2:0]) * 32'(MAX_MAP_WIDTH)
                       + 32'(cx_ff[CELL_W-2:0]));
   assign w_eff   = (32'(map_width_ff) < 32'(MAX_MAP_WIDTH))
                    ? 9'(map_width_ff) : 9'(MAX_MAP_WIDTH);
   assign h_eff   = (32'(map_height_ff) < 32'(MAX_MAP_HEIGHT))
                    ? 9'(map_height_ff) : 9'(MAX_MAP_HEIGHT);
   assign in_map  = !cx_ff[CELL_W-1] && !cy_ff[CELL_W-1]
                 && ({1'b0, cx_ff[CELL_W-2:0]} < 12'(w_eff))
                 && ({1'b0, cy_ff[CELL_W-2:0]} < 12'(h_eff));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem_ff[clr_addr_ff] <= 8'd0;
      end else if (cmd.map_wr && wr_ok) begin
         mem_ff[wr_addr] <= req_data.cell_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         rd_ff     <= mem_ff[rd_addr];
         in_map_ff <= in_map;
         prod_ff   <= (axis_ff ? dx_ff : dy_ff) * $signed({1'b0, t_ff[23:0]});
      end
   end

   // hit point
   logic signed [28:0] other_c, bound_c, end_x, end_y;

   assign other_c = 29'(axis_ff ? sx_ff : sy_ff) + 29'(prod_ff >>> 16);
   assign bound_c = {nb_ff, 16'b0};
   assign end_x   = axis_ff ? other_c : bound_c;
   assign end_y   = axis_ff ? bound_c : other_c;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (cmd.rsp_miss) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff.hit         <= 1'b1;
            rsp_ff.end_x       <= end_x[23:0];
            rsp_ff.end_y       <= end_y[23:0];
            rsp_ff.distance    <= t_ff[23:0];
            rsp_ff.wall_type   <= rd_ff;
            rsp_ff.normal_is_y <= axis_ff;
         end
      end
   end

   assign rsp_data    = rsp_ff;
   assign st.clr_done = (clr_addr_ff == AW'(DEPTH - 1));
   assign st.div_done = div_fin_ff;
   assign st.zero_dir = (dx_ff == '0) && (dy_ff == '0);
   assign st.t_over   = (t_ff > T_W'(max_range_ff));
   assign st.cell_hit = in_map_ff && (rd_ff != 8'd0);
   assign st.end_fits = ((end_x[28:23] == 6'h00) || (end_x[28:23] == 6'h3F))
                     && ((end_y[28:23] == 6'h00) || (end_y[28:23] == 6'h3F));

endmodule

/* rtl/grid_ray_traversal.sv */
// Top level: 2D wall map with a fixed-point DDA ray caster.
// After reset the map is swept to zero, all MAX_MAP_WIDTH*MAX_MAP_HEIGHT cells
// (4096 by default); requests are held off until then, configuration is open.
// A map write is taken while the block stays idle. A ray cast with a nonzero
// direction runs four serial divider passes (one quotient bit per cycle), then
// walks each crossed cell (step, map read, check), then loads the result register.
module grid_ray_traversal #(
   parameter int MAX_MAP_WIDTH  = 64,
   parameter int MAX_MAP_HEIGHT = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  grt_pkg::grt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output grt_pkg::grt_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [23:0]          csr_wdata
);
   import grt_pkg::*;

   grt_cmd_type    cmd;
   grt_status_type st;

   assign csr_ready = 1'b1;

   grt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_data.kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   grt_dpath #(
      .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
      .MAX_MAP_HEIGHT (MAX_MAP_HEIGHT)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .st        (st)
   );

endmodule

/* rtl/grt_checker.sv */
// Port-level checks for the ray traversal block, bound to the top level.
module grt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input grt_pkg::grt_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input grt_pkg::grt_rsp_type rsp_data
);
   import grt_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data == '0)
      else $error("miss result carries nonzero fields");

   a_hit_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.wall_type != 8'd0)
      else $error("hit on an empty cell");

   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == KIND_RAY_CAST |=> !req_ready)
      else $error("new request taken while a ray is in flight");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block active right after reset");

endmodule

bind grid_ray_traversal grt_checker u_grt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* verif/testbench.sv */
// Testbench for grid_ray_traversal: map writes and DDA ray casts checked against a predictor.
`timescale 1ns / 1ps

module testbench;
   import grt_pkg::*;

   typedef struct {
      grt_req_type req;
      bit          drain_first;
   } pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   grt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   grt_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   pending_type pending_q[$];
   grt_rsp_type hit_q[$];
   logic [7:0]  wall_map[0:4095];
   int unsigned cols_used = 64;
   int unsigned rows_used = 64;
   longint      range_limit = 64'h100000;
   int          errors = 0;
   bit          req_taken = 1'b0;
   bit          long_hold = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_mode = 0;
   int          mode_left = 0;

   grid_ray_traversal DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #200_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic report(string what, longint exp_v, longint got_v);
      $display("MISMATCH %s: expected %h, got %h", what, exp_v, got_v);
      errors++;
   endtask

   // crossing parameter of boundary b, Q8.16, truncated
   function automatic longint cross_at(longint b, longint s, longint d);
      longint num;
      longint ad;
      num = b * 65536 - s;
      if (num < 0) num = -num;
      ad = (d < 0) ? -d : d;
      return (num <<< 16) / ad;
   endfunction

   function automatic grt_rsp_type trace_ray(grt_req_type r);
      grt_rsp_type res;
      longint sx, sy, dx, dy, cx, cy, bx, by, tx, ty, t, ex, ey, w, h;
      bit take_x, ny;
      res = '0;
      sx = $signed(r.start_x);
      sy = $signed(r.start_y);
      dx = $signed(r.dir_x);
      dy = $signed(r.dir_y);
      if (dx == 0 && dy == 0) return res;
      w = (cols_used < 64) ? cols_used : 64;
      h = (rows_used < 64) ? rows_used : 64;
      cx = sx >>> 16;
      cy = sy >>> 16;
      bx = (dx > 0) ? cx + 1 : cx;
      by = (dy > 0) ? cy + 1 : cy;
      forever begin
         tx = (dx != 0) ? cross_at(bx, sx, dx) : 0;
         ty = (dy != 0) ? cross_at(by, sy, dy) : 0;
         if (dx == 0) take_x = 0;
         else if (dy == 0) take_x = 1;
         else take_x = (tx <= ty);
         if (take_x) begin
            t = tx;
            ex = bx * 65536;
            ey = sy + ((dy * t) >>> 16);
            cx = (dx > 0) ? cx + 1 : cx - 1;
            bx = (dx > 0) ? bx + 1 : bx - 1;
            ny = 0;
         end else begin
            t = ty;
            ey = by * 65536;
            ex = sx + ((dx * t) >>> 16);
            cy = (dy > 0) ? cy + 1 : cy - 1;
            by = (dy > 0) ? by + 1 : by - 1;
            ny = 1;
         end
         if (t > range_limit) return res;
         if (cx >= 0 && cy >= 0 && cx < w && cy < h && wall_map[cy * 64 + cx] != 0) begin
            if (ex < -8388608 || ex > 8388607 || ey < -8388608 || ey > 8388607)
               return res;
            res.hit = 1'b1;
            res.end_x = ex[23:0];
            res.end_y = ey[23:0];
            res.distance = t[23:0];
            res.wall_type = wall_map[cy * 64 + cx];
            res.normal_is_y = ny;
            return res;
         end
      end
   endfunction

   // sample both channels and the register port at the rising edge
   always @(posedge clock) begin
      grt_rsp_type exp_r;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            case (grt_csr_type'(csr_index))
               CSR_MAP_WIDTH:  cols_used = csr_wdata[6:0];
               CSR_MAP_HEIGHT: rows_used = csr_wdata[6:0];
               CSR_MAX_RANGE:  range_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.kind == KIND_MAP_WRITE)
               wall_map[{req_data.cell_y, req_data.cell_x}] = req_data.cell_value;
            else
               hit_q.push_back(trace_ray(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (hit_q.size() == 0) begin
               report("unexpected response", 0, longint'(rsp_data.hit));
            end else begin
               exp_r = hit_q.pop_front();
               if (rsp_data.hit != exp_r.hit) report("hit", exp_r.hit, rsp_data.hit);
               if (rsp_data.end_x != exp_r.end_x) report("end_x", exp_r.end_x, rsp_data.end_x);
               if (rsp_data.end_y != exp_r.end_y) report("end_y", exp_r.end_y, rsp_data.end_y);
               if (rsp_data.distance != exp_r.distance)
                  report("distance", exp_r.distance, rsp_data.distance);
               if (rsp_data.wall_type != exp_r.wall_type)
                  report("wall_type", exp_r.wall_type, rsp_data.wall_type);
               if (rsp_data.normal_is_y != exp_r.normal_is_y)
                  report("normal_is_y", exp_r.normal_is_y, rsp_data.normal_is_y);
            end
         end
      end
   end

   // request driver: bursts with gaps, hold until accepted
   always @(negedge clock) begin
      pending_type p;
      logic        nxt_valid;
      grt_req_type nxt_data;
      nxt_valid = req_valid;
      nxt_data = req_data;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         nxt_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_q.size() > 0) begin
            p = pending_q[0];
            if (!p.drain_first || (hit_q.size() == 0 && !rsp_valid)) begin
               void'(pending_q.pop_front());
               nxt_valid = 1'b1;
               nxt_data = p.req;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end
               burst_left--;
            end
         end
      end
      req_valid <= nxt_valid;
      req_data <= nxt_data;
   end

   // response stalls change pattern every so often
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 400);
      end else begin
         mode_left--;
      end
      if (long_hold) rsp_ready <= 1'b0;
      else case (stall_mode)
         0, 1: rsp_ready <= 1'b1;
         2: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // hold off responses for a long stretch while requests keep coming
   initial begin
      @(negedge reset);
      repeat (9000) @(posedge clock);
      long_hold = 1'b1;
      repeat (3000) @(posedge clock);
      long_hold = 1'b0;
   end

   task automatic write_csr(grt_csr_type idx, logic [23:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(int w, int h, logic [23:0] rng);
      write_csr(CSR_MAP_WIDTH, 24'(w));
      write_csr(CSR_MAP_HEIGHT, 24'(h));
      write_csr(CSR_MAX_RANGE, rng);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_write(int x, int y, int v);
      pending_type p;
      p.req = '0;
      p.req.kind = KIND_MAP_WRITE;
      p.req.cell_x = 6'(x);
      p.req.cell_y = 6'(y);
      p.req.cell_value = 8'(v);
      p.drain_first = 0;
      pending_q.push_back(p);
   endtask

   task automatic push_cast(int sx, int sy, int dx, int dy);
      pending_type p;
      p.req = '0;
      p.req.kind = KIND_RAY_CAST;
      p.req.start_x = 24'(sx);
      p.req.start_y = 24'(sy);
      p.req.dir_x = 18'(dx);
      p.req.dir_y = 18'(dy);
      p.drain_first = 0;
      pending_q.push_back(p);
   endtask

   task automatic push_random(int n, int w);
      pending_type  p;
      int           span;
      logic [127:0] raw;
      span = (w < 1) ? 64 : ((w > 64) ? 64 : w);
      repeat (n) begin
         raw = {$urandom, $urandom, $urandom, $urandom};
         p.req = raw[$bits(grt_req_type)-1:0];
         p.drain_first = ($urandom_range(0, 60) == 0);
         if ($urandom_range(0, 9) < 4) begin
            p.req.kind = KIND_MAP_WRITE;
            if ($urandom_range(0, 3) != 0) p.req.cell_x = 6'($urandom_range(0, span - 1));
            if ($urandom_range(0, 4) == 0) p.req.cell_value = '0;
         end else begin
            p.req.kind = KIND_RAY_CAST;
            if ($urandom_range(0, 4) != 0) begin
               p.req.start_x = 24'($urandom_range(0, span * 65536 - 1));
               p.req.start_y = 24'($urandom_range(0, 64 * 65536 - 1));
            end
            case ($urandom_range(0, 9))
               0: p.req.dir_x = '0;
               1: p.req.dir_y = '0;
               2: begin p.req.dir_x = '0; p.req.dir_y = '0; end
               3: p.req.dir_x = 18'($signed($urandom_range(0, 64)) - 32);
               default: ;
            endcase
         end
         pending_q.push_back(p);
      end
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || req_valid || hit_q.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < 4096; i++) wall_map[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: walls on edges and corners, axis, diagonal, zero and extreme rays
      push_write(0, 0, 255);
      push_write(63, 63, 1);
      push_write(10, 5, 7);
      push_write(5, 10, 128);
      push_write(63, 0, 3);
      push_write(0, 63, 64);
      push_write(9, 4, 0);
      push_write(12, 12, 9);
      push_cast(2 * 65536 + 32768, 5 * 65536 + 32768, 65536, 0);
      push_cast(5 * 65536 + 32768, 2 * 65536 + 32768, 0, 65536);
      push_cast(3 * 65536, 3 * 65536, 0, 0);
      push_cast(8 * 65536 + 32768, 8 * 65536 + 32768, 65536, 65536);
      push_cast(-3 * 65536, 32768, 65536, 0);
      push_cast(62 * 65536 + 32768, 62 * 65536 + 32768, 131071, 131071);
      push_cast(-8388608, -8388608, 131071, 131071);
      push_cast(8388607, 8388607, -131072, -131072);
      push_cast(32768, 62 * 65536, 0, -131072);
      push_cast(30 * 65536, 30 * 65536, -131072, 1);
      push_cast(30 * 65536, 30 * 65536, 1, -131072);
      push_cast(20 * 65536, 40 * 65536, -1, 0);
      push_cast(60 * 65536 + 1, 32768, 65536, 0);
      push_random(150, 64);
      drain();

      set_config(127, 127, 24'hFFFFFF);
      push_random(80, 64);
      drain();
      set_config(0, 5, 24'h100000);
      push_random(100, 64);
      drain();
      set_config(1, 1, 24'h000000);
      push_write(0, 0, 2);
      push_cast(-65536, 32768, 65536, 0);
      push_random(100, 1);
      drain();
      set_config(20, 37, 24'($urandom_range(0, 24'h200000)));
      push_random(200, 20);
      drain();
      set_config(64, 0, 24'h080000);
      push_random(80, 64);
      drain();
      set_config(64, 64, 24'h100000);
      push_random(320, 64);
      drain();

      if (errors == 0 && hit_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
